// File: hw/rtl/rtw_pkg.sv
// Shared types and constants for the RTT trend window scaler.
package rtw_pkg;

  localparam int FIELD_W     = 32;
  localparam int IN_TDATA_W  = 4 * FIELD_W;
  localparam int OUT_TDATA_W = 48;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_EWMA_WEIGHT   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SENSITIVITY   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAMMA_FLOOR   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAMMA_CEILING = 8'd3;

  localparam int WEIGHT_W = 16;
  localparam int GAMMA_W  = 16;
  localparam int FLOOR_W  = 14;

  localparam logic [WEIGHT_W-1:0] EWMA_WEIGHT_RST = 16'd8192;
  localparam logic [WEIGHT_W-1:0] SENSITIVITY_RST = 16'd128;
  localparam logic [FLOOR_W-1:0]  GAMMA_FLOOR_RST = 14'd4096;
  localparam logic [GAMMA_W-1:0]  GAMMA_CEIL_RST  = 16'd12288;
  localparam logic [GAMMA_W-1:0]  GAMMA_ONE       = 16'd8192;

  localparam int FRAC_W     = 16;  // fraction bits of smoothed RTT and ratio
  localparam int GAMMA_FRAC = 13;

  localparam int RATIO_QW = 41;
  localparam logic [RATIO_QW-1:0] RATIO_CAP = {1'b1, 40'd0};

  localparam int DEN_PROD_W = RATIO_QW + WEIGHT_W;
  localparam int DEN_W      = DEN_PROD_W + 2;
  localparam logic [DEN_W-1:0] DEN_ONE       = DEN_W'(64'd16777216);   // 1.0 in Q.24
  localparam logic [DEN_W-1:0] DEN_SAT_LIMIT = DEN_W'(64'd1048576);    // 2^20
  localparam logic [DEN_W-1:0] DEN_DIV_LIMIT = DEN_W'(64'd137438953472); // 2^37

  localparam int GDIV_DVS_W = 38;
  localparam int GRAW_W     = 17;
  localparam logic [GDIV_DVS_W-1:0] GDIV_REM_INIT = GDIV_DVS_W'(64'd1048576);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SMP_MUL,
    ST_RATIO_DIV,
    ST_DEN_START,
    ST_DEN_MUL,
    ST_DEN_CLASS,
    ST_GAMMA_DIV,
    ST_CLAMP,
    ST_SCALE,
    ST_SUM,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic take;
    logic dispatch;
    logic smp_start;
    logic smp_update;
    logic gamma_one;
    logic ratio_start;
    logic ratio_take;
    logic den_start;
    logic den_calc;
    logic den_class;
    logic graw_take;
    logic clamp;
    logic scale;
    logic sum;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic sample_valid;
    logic seen;
    logic slow_start;
    logic ratio_ovf;
    logic need_div;
    logic mul_busy;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/rtt_trend_window_scaler_core.sv
// Top level: RTT trend window scaler, controller plus datapath.
// One request in flight. An RTT sample after the first one runs the 16-step
// serial EWMA multiply. A slow-start window request goes straight to the result.
// A congestion-avoidance window request may use the 41-step ratio divider,
// the 16-step k*ratio multiply and the 17-step gamma divider.
// Synchronous active-high reset: idle, config at defaults, RTT state cleared.
module rtt_trend_window_scaler_core #(
  parameter int RTT_WIDTH    = 32,
  parameter int WINDOW_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // rtt_us[31:0], cwnd[63:32], ssthresh[95:64], cubic_cwnd[127:96]
  input  logic [rtw_pkg::IN_TDATA_W-1:0]  s_tdata,
  // kind
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // new_cwnd[31:0], gamma[47:32]
  output logic [rtw_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rtw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rtw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rtw_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  rtw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtw_datapath #(
    .RTT_WIDTH    (RTT_WIDTH),
    .WINDOW_WIDTH (WINDOW_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_kind   (s_tuser),
    .in_data   (s_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// File: hw/rtl/rtw_mul.sv
// Shift-add serial multiplier, one multiplier bit per cycle.
module rtw_mul #(
  parameter int MC_W = 48,
  parameter int MP_W = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MC_W-1:0]      mcand,
  input  logic [MP_W-1:0]      mplier,
  output logic                 busy,
  output logic [MC_W+MP_W-1:0] product
);
  localparam int P_W = MC_W + MP_W;

  logic [P_W-1:0]  acc;
  logic [P_W-1:0]  mc;
  logic [MP_W-1:0] mp;

  assign busy    = (mp != '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      mp <= '0;
    end else if (start) begin
      mp <= mplier;
    end else if (busy) begin
      mp <= mp >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      mc  <= P_W'(mcand);
    end else if (busy) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= mc << 1;
    end
  end

endmodule

// File: hw/rtl/rtw_div.sv
// Radix-2 restoring divider with preloaded partial remainder.
module rtw_div #(
  parameter int DV_W = 38,
  parameter int Q_W  = 41
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DV_W-1:0]          rem_init,
  input  logic [Q_W-1:0]           dividend,
  input  logic [DV_W-1:0]          divisor,
  input  logic [$clog2(Q_W+1)-1:0] steps,
  output logic                     busy,
  output logic [Q_W-1:0]           quotient
);
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DV_W-1:0]  rem;
  logic [DV_W-1:0]  dvs;
  logic [Q_W-1:0]   dvd;
  logic [Q_W-1:0]   q;
  logic [DV_W:0]    trial;
  logic [DV_W:0]    diff;
  logic             ge;

  assign busy     = (cnt != '0);
  assign quotient = q;
  assign trial    = {rem, dvd[Q_W-1]};
  assign ge       = (trial >= {1'b0, dvs});
  assign diff     = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= steps;
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      dvs <= divisor;
      dvd <= dividend;
      q   <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
      dvd <= dvd << 1;
      q   <= {q[Q_W-2:0], ge};
    end
  end

endmodule

// File: hw/rtl/rtw_datapath.sv
// Datapath: config registers, RTT state, gamma computation and output register.
module rtw_datapath #(
  parameter int RTT_WIDTH    = 32,
  parameter int WINDOW_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rtw_pkg::cmd_t                   cmd,
  output rtw_pkg::stat_t                  stat,
  input  logic                            in_kind,
  input  logic [rtw_pkg::IN_TDATA_W-1:0]  in_data,
  input  logic                            cfg_we,
  input  logic [rtw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rtw_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rtw_pkg::OUT_TDATA_W-1:0] out_data
);
  import rtw_pkg::*;

  localparam int SW    = RTT_WIDTH + FRAC_W;
  localparam int WW    = WINDOW_WIDTH;
  localparam int MC_W  = (SW > RATIO_QW) ? SW : RATIO_QW;
  localparam int DIV_W = MC_W + 1;
  localparam int HI_W  = DIV_W - RATIO_QW;
  localparam int DV_W  = (RTT_WIDTH > GDIV_DVS_W) ? RTT_WIDTH : GDIV_DVS_W;
  localparam int CNT_W = $clog2(RATIO_QW + 1);
  localparam int ADJ_W = GAMMA_W + WW;

  // configuration
  logic [WEIGHT_W-1:0] ewma_weight;
  logic [WEIGHT_W-1:0] sensitivity;
  logic [FLOOR_W-1:0]  gamma_floor;
  logic [GAMMA_W-1:0]  gamma_ceiling;

  // RTT state
  logic [RTT_WIDTH-1:0] min_rtt;
  logic [SW-1:0]        smooth;
  logic                 seen;

  // current request
  logic                 kind;
  logic [RTT_WIDTH-1:0] smp;
  logic [WW-1:0]        cwnd;
  logic [WW-1:0]        ssth;
  logic [WW-1:0]        cubic;

  // working registers
  logic                 ewma_up;
  logic [RATIO_QW-1:0]  ratio;
  logic [DEN_W-1:0]     den;
  logic                 raw_hi;
  logic [GRAW_W-1:0]    graw;
  logic [GAMMA_W-1:0]   gamma;
  logic [WW-1:0]        inc;
  logic [ADJ_W-1:0]     adj;
  logic [WW-1:0]        sum;

  // combinational
  logic [SW-1:0]          big;
  logic                   big_ge;
  logic [SW-1:0]          diff;
  logic [DIV_W-1:0]       smooth_ext;
  logic [HI_W-1:0]        smooth_hi;
  logic [RATIO_QW-1:0]    smooth_lo;
  logic                   ratio_ovf;
  logic                   den_neg;
  logic                   den_sat;
  logic                   need_div;
  logic [GAMMA_W-1:0]     g_hi;
  logic [GAMMA_W-1:0]     g_clamped;
  logic [SW-1:0]          corr;

  logic                   mul_start;
  logic [MC_W-1:0]        mul_mcand;
  logic [WEIGHT_W-1:0]    mul_mplier;
  logic                   mul_busy;
  logic [MC_W+WEIGHT_W-1:0] mul_prod;

  logic                   div_start;
  logic [DV_W-1:0]        div_rem_init;
  logic [RATIO_QW-1:0]    div_dividend;
  logic [DV_W-1:0]        div_divisor;
  logic [CNT_W-1:0]       div_steps;
  logic                   div_busy;
  logic [RATIO_QW-1:0]    div_q;

  assign big        = {smp, FRAC_W'(0)};
  assign big_ge     = (big >= smooth);
  assign diff       = big_ge ? (big - smooth) : (smooth - big);
  assign smooth_ext = DIV_W'(smooth);
  assign smooth_hi  = smooth_ext[DIV_W-1:RATIO_QW];
  assign smooth_lo  = smooth_ext[RATIO_QW-1:0];
  assign ratio_ovf  = (DV_W'(smooth_hi) >= DV_W'(min_rtt));
  assign den_neg    = den[DEN_W-1];
  assign den_sat    = !den_neg && (den <= DEN_SAT_LIMIT);
  assign need_div   = !den_neg && !den_sat && (den <= DEN_DIV_LIMIT);
  assign corr       = mul_prod[SW+FRAC_W-1:FRAC_W];

  always_comb begin
    if (raw_hi || (graw > GRAW_W'(gamma_ceiling))) begin
      g_hi = gamma_ceiling;
    end else begin
      g_hi = graw[GAMMA_W-1:0];
    end
    if (g_hi < GAMMA_W'(gamma_floor)) begin
      g_clamped = GAMMA_W'(gamma_floor);
    end else begin
      g_clamped = g_hi;
    end
  end

  assign stat.kind         = kind;
  assign stat.sample_valid = (smp != '0) && (smp != '1);
  assign stat.seen         = seen;
  assign stat.slow_start   = (cwnd < ssth);
  assign stat.ratio_ovf    = ratio_ovf;
  assign stat.need_div     = need_div;
  assign stat.mul_busy     = mul_busy;
  assign stat.div_busy     = div_busy;
  assign stat.out_free     = !out_valid || out_ready;

  // shared multiplier: EWMA correction and k * ratio
  assign mul_start  = (cmd.smp_start && seen) || cmd.den_start;
  assign mul_mcand  = cmd.den_start ? MC_W'(ratio) : MC_W'(diff);
  assign mul_mplier = cmd.den_start ? sensitivity : ewma_weight;

  rtw_mul #(
    .MC_W (MC_W),
    .MP_W (WEIGHT_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .busy    (mul_busy),
    .product (mul_prod)
  );

  // shared divider: smooth / min_rtt and 2^37 / den
  assign div_start    = (cmd.ratio_start && !ratio_ovf) || (cmd.den_class && need_div);
  assign div_rem_init = cmd.den_class ? DV_W'(GDIV_REM_INIT) : DV_W'(smooth_hi);
  assign div_dividend = cmd.den_class ? '0 : smooth_lo;
  assign div_divisor  = cmd.den_class ? DV_W'(den[GDIV_DVS_W-1:0]) : DV_W'(min_rtt);
  assign div_steps    = cmd.den_class ? CNT_W'(GRAW_W) : CNT_W'(RATIO_QW);

  rtw_div #(
    .DV_W (DV_W),
    .Q_W  (RATIO_QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      ewma_weight   <= EWMA_WEIGHT_RST;
      sensitivity   <= SENSITIVITY_RST;
      gamma_floor   <= GAMMA_FLOOR_RST;
      gamma_ceiling <= GAMMA_CEIL_RST;
      min_rtt       <= '1;
      smooth        <= '0;
      seen          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_EWMA_WEIGHT:   ewma_weight   <= cfg_data[WEIGHT_W-1:0];
          CFG_SENSITIVITY:   sensitivity   <= cfg_data[WEIGHT_W-1:0];
          CFG_GAMMA_FLOOR:   gamma_floor   <= cfg_data[FLOOR_W-1:0];
          CFG_GAMMA_CEILING: gamma_ceiling <= cfg_data[GAMMA_W-1:0];
          default: ;
        endcase
      end
      if (cmd.smp_start) begin
        if (smp < min_rtt) begin
          min_rtt <= smp;
        end
        if (!seen) begin
          smooth <= big;
          seen   <= 1'b1;
        end
      end
      if (cmd.smp_update) begin
        smooth <= ewma_up ? (smooth + corr) : (smooth - corr);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind  <= in_kind;
      smp   <= RTT_WIDTH'(in_data[FIELD_W-1:0]);
      cwnd  <= WW'(in_data[2*FIELD_W-1:FIELD_W]);
      ssth  <= WW'(in_data[3*FIELD_W-1:2*FIELD_W]);
      cubic <= WW'(in_data[4*FIELD_W-1:3*FIELD_W]);
    end
    if (cmd.dispatch) begin
      inc <= (cubic > cwnd) ? (cubic - cwnd) : '0;
    end
    if (cmd.smp_start) begin
      ewma_up <= big_ge;
    end
    if (cmd.ratio_start && ratio_ovf) begin
      ratio <= RATIO_CAP;
    end
    if (cmd.ratio_take) begin
      ratio <= (div_q > RATIO_CAP) ? RATIO_CAP : div_q;
    end
    if (cmd.den_calc) begin
      den <= DEN_W'(mul_prod[DEN_PROD_W-1:0]) + DEN_ONE
             - DEN_W'({sensitivity, FRAC_W'(0)});
    end
    if (cmd.den_class) begin
      raw_hi <= den_sat;
      graw   <= '0;
    end
    if (cmd.graw_take) begin
      graw <= div_q[GRAW_W-1:0];
    end
    if (cmd.gamma_one) begin
      gamma <= GAMMA_ONE;
    end
    if (cmd.clamp) begin
      gamma <= g_clamped;
    end
    if (cmd.scale) begin
      adj <= ADJ_W'(gamma) * ADJ_W'(inc);
    end
    if (cmd.sum) begin
      sum <= cwnd + adj[WW+GAMMA_FRAC-1:GAMMA_FRAC];
    end
    if (cmd.out_load) begin
      if (cwnd < ssth) begin
        out_data <= {GAMMA_ONE, FIELD_W'(cubic)};
      end else begin
        out_data <= {gamma, FIELD_W'(sum)};
      end
    end
  end

endmodule

// File: hw/rtl/rtw_ctrl.sv
// Controller state machine sequencing sample and window requests.
module rtw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rtw_pkg::stat_t stat,
  output rtw_pkg::cmd_t  cmd
);
  import rtw_pkg::*;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.dispatch = 1'b1;
        if (!stat.kind) begin
          if (stat.sample_valid) begin
            cmd.smp_start = 1'b1;
            state_next    = stat.seen ? ST_SMP_MUL : ST_IDLE;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (stat.slow_start) begin
          state_next = ST_RESULT;
        end else if (!stat.seen) begin
          cmd.gamma_one = 1'b1;
          state_next    = ST_SCALE;
        end else begin
          cmd.ratio_start = 1'b1;
          state_next      = stat.ratio_ovf ? ST_DEN_START : ST_RATIO_DIV;
        end
      end
      ST_SMP_MUL: begin
        if (!stat.mul_busy) begin
          cmd.smp_update = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_RATIO_DIV: begin
        if (!stat.div_busy) begin
          cmd.ratio_take = 1'b1;
          state_next     = ST_DEN_START;
        end
      end
      ST_DEN_START: begin
        cmd.den_start = 1'b1;
        state_next    = ST_DEN_MUL;
      end
      ST_DEN_MUL: begin
        if (!stat.mul_busy) begin
          cmd.den_calc = 1'b1;
          state_next   = ST_DEN_CLASS;
        end
      end
      ST_DEN_CLASS: begin
        cmd.den_class = 1'b1;
        state_next    = stat.need_div ? ST_GAMMA_DIV : ST_CLAMP;
      end
      ST_GAMMA_DIV: begin
        if (!stat.div_busy) begin
          cmd.graw_take = 1'b1;
          state_next    = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
